// ===== sv/pcm_dac_sample_engine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// PCM DAC sample engine - assertion macros
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PCM_DAC_SAMPLE_ENGINE_UNIT_DEFINES_SVH
`define PCM_DAC_SAMPLE_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTH
`define PDSE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pdse check failed");
`define PDSE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pdse check failed");
`else
`define PDSE_ASSERT(lbl, clk, rst, prop)
`define PDSE_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== sv/pdse_pkg.sv =====
// ----------------------------------------------------------------------------
// PCM DAC sample engine - package
// Item codes, register selects, bit masks and item/result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdse_pkg;

  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [2:0] REG_STATUS   = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_FILTER   = 3'd2;
  localparam logic [2:0] REG_PCM      = 3'd3;
  localparam logic [2:0] REG_FORMAT   = 3'd4;
  localparam logic [2:0] REG_COUNT_LO = 3'd5;
  localparam logic [2:0] REG_COUNT_HI = 3'd6;

  localparam logic CFG_AUTO_RELOAD  = 1'b0;
  localparam logic CFG_COUNT_RELOAD = 1'b1;

  localparam logic [4:0]  ST_SAMP     = 5'h04;
  localparam logic [4:0]  ST_PCM      = 5'h08;
  localparam logic [7:0]  MASK_RD_SET = 8'h20;
  localparam int          PC_MONO_BIT = 5;
  localparam int          PC_ENA_BIT  = 6;
  localparam int          PC_DMA_BIT  = 7;
  localparam int          FMT_16_BIT  = 2;
  localparam int          FMT_INV_BIT = 4;
  localparam int          FILT_ON_BIT = 5;
  localparam logic [7:0]  MSB_FLIP8   = 8'h80;
  localparam logic [15:0] MSB_FLIP16  = 16'h8000;
  localparam logic [15:0] EVEN_MASK   = 16'hfffe;
  localparam logic [7:0]  RD_NONE     = 8'hff;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 48;

  typedef struct packed {
    logic [1:0]  func;
    logic [2:0]  reg_sel;
    logic [7:0]  write_data;
    logic [15:0] dma_word;
    logic        count_gate;
  } item_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               irq_pending;
    logic               count_expired;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/pdse_core.sv =====
// ----------------------------------------------------------------------------
// PCM DAC sample engine - register file and tick logic
// Holds all engine state; updates it for one item per fire and forms the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdse_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire pdse_pkg::item_t   item,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [15:0]       cfg_data,
  output pdse_pkg::result_t      result
);

  logic        auto_reload;
  logic [15:0] count_reload;
  logic [4:0]  irq_status, irq_status_next;
  logic [4:0]  irq_mask, irq_mask_next;
  logic [7:0]  filter_ctrl, filter_ctrl_next;
  logic [7:0]  pcm_mode, pcm_mode_next;
  logic [7:0]  format_ctrl, format_ctrl_next;
  logic [15:0] left_hold, left_hold_next;
  logic [15:0] right_hold, right_hold_next;
  logic        stereo_phase, stereo_phase_next;
  logic [15:0] sample_count, sample_count_next;
  logic        count_stopped, count_stopped_next;
  logic        expired;

  logic        wide;
  logic [15:0] conv;
  logic [15:0] sample;
  logic [15:0] count_dec;
  logic [7:0]  rd;

  assign wide      = format_ctrl[pdse_pkg::FMT_16_BIT];
  assign conv      = wide ? item.dma_word
                          : {item.dma_word[7:0] ^ pdse_pkg::MSB_FLIP8, 8'h00};
  assign sample    = format_ctrl[pdse_pkg::FMT_INV_BIT] ? (conv ^ pdse_pkg::MSB_FLIP16)
                                                        : conv;
  assign count_dec = sample_count - (wide ? 16'd2 : 16'd1);

  always_comb begin
    unique case (item.reg_sel)
      pdse_pkg::REG_STATUS:   rd = {3'b000, irq_status};
      pdse_pkg::REG_MASK:     rd = {3'b000, irq_mask} | pdse_pkg::MASK_RD_SET;
      pdse_pkg::REG_FILTER:   rd = filter_ctrl;
      pdse_pkg::REG_PCM:      rd = pcm_mode;
      pdse_pkg::REG_FORMAT:   rd = format_ctrl;
      pdse_pkg::REG_COUNT_LO: rd = sample_count[7:0];
      pdse_pkg::REG_COUNT_HI: rd = sample_count[15:8];
      default:                rd = pdse_pkg::RD_NONE;
    endcase
  end

  always_comb begin
    irq_status_next    = irq_status;
    irq_mask_next      = irq_mask;
    filter_ctrl_next   = filter_ctrl;
    pcm_mode_next      = pcm_mode;
    format_ctrl_next   = format_ctrl;
    left_hold_next     = left_hold;
    right_hold_next    = right_hold;
    stereo_phase_next  = stereo_phase;
    sample_count_next  = sample_count;
    count_stopped_next = count_stopped;
    expired            = 1'b0;
    unique case (item.func)
      pdse_pkg::FUNC_TICK: begin
        irq_status_next = irq_status | pdse_pkg::ST_SAMP;
        if (item.count_gate && !count_stopped) begin
          if (pcm_mode[pdse_pkg::PC_ENA_BIT] || pcm_mode[pdse_pkg::PC_DMA_BIT]) begin
            if (pcm_mode[pdse_pkg::PC_MONO_BIT]) begin
              left_hold_next  = sample;
              right_hold_next = sample;
            end else begin
              if (stereo_phase) begin
                right_hold_next = sample;
              end else begin
                left_hold_next = sample;
              end
              stereo_phase_next = ~stereo_phase;
            end
          end
          sample_count_next = count_dec;
          if (count_dec == 16'd0) begin
            if (auto_reload) begin
              sample_count_next = count_reload & (wide ? pdse_pkg::EVEN_MASK : 16'hffff);
            end else begin
              count_stopped_next = 1'b1;
            end
            irq_status_next = irq_status | pdse_pkg::ST_SAMP | pdse_pkg::ST_PCM;
            expired         = 1'b1;
          end
        end
      end
      pdse_pkg::FUNC_WRITE: begin
        unique case (item.reg_sel)
          pdse_pkg::REG_STATUS: irq_status_next = irq_status & ~item.write_data[4:0];
          pdse_pkg::REG_MASK:   irq_mask_next   = item.write_data[4:0];
          pdse_pkg::REG_FILTER: filter_ctrl_next = item.write_data;
          pdse_pkg::REG_PCM: begin
            if (item.write_data[pdse_pkg::PC_ENA_BIT] && !pcm_mode[pdse_pkg::PC_ENA_BIT]) begin
              stereo_phase_next = 1'b0;
            end
            pcm_mode_next = item.write_data;
          end
          pdse_pkg::REG_FORMAT: format_ctrl_next = item.write_data;
          pdse_pkg::REG_COUNT_LO: begin
            sample_count_next  = {sample_count[15:8], item.write_data};
            count_stopped_next = 1'b0;
          end
          pdse_pkg::REG_COUNT_HI: begin
            sample_count_next  = {item.write_data, sample_count[7:0]};
            count_stopped_next = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    result.read_data     = (item.func == pdse_pkg::FUNC_READ) ? rd : pdse_pkg::RD_NONE;
    result.left_sample   = filter_ctrl_next[pdse_pkg::FILT_ON_BIT] ? left_hold_next : 16'sd0;
    result.right_sample  = filter_ctrl_next[pdse_pkg::FILT_ON_BIT] ? right_hold_next : 16'sd0;
    result.irq_pending   = |(irq_status_next & irq_mask_next);
    result.count_expired = expired;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_reload  <= 1'b0;
      count_reload <= 16'd0;
    end else if (cfg_we) begin
      if (cfg_index == pdse_pkg::CFG_AUTO_RELOAD) begin
        auto_reload <= cfg_data[0];
      end else begin
        count_reload <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_status    <= 5'd0;
      irq_mask      <= 5'd0;
      filter_ctrl   <= 8'd0;
      pcm_mode      <= 8'd0;
      format_ctrl   <= 8'd0;
      left_hold     <= 16'd0;
      right_hold    <= 16'd0;
      stereo_phase  <= 1'b0;
      sample_count  <= 16'd0;
      count_stopped <= 1'b0;
    end else if (fire) begin
      irq_status    <= irq_status_next;
      irq_mask      <= irq_mask_next;
      filter_ctrl   <= filter_ctrl_next;
      pcm_mode      <= pcm_mode_next;
      format_ctrl   <= format_ctrl_next;
      left_hold     <= left_hold_next;
      right_hold    <= right_hold_next;
      stereo_phase  <= stereo_phase_next;
      sample_count  <= sample_count_next;
      count_stopped <= count_stopped_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pcm_dac_sample_engine_unit.sv =====
// ----------------------------------------------------------------------------
// PCM DAC sample engine - top level
// Stream front end for the sound-card PCM output register file.
//
// Channels: s_* carries one item per handshake (tick, register write or
// register read, kind in s_tuser). m_* returns exactly one result per item.
// cfg_* writes the reload controls: index 0 auto_reload, index 1
// count_reload; cfg_ready is always high. Write them only while idle.
// Path: an accepted item waits in the input register, and its result is then
// held in the result register.
// Throughput: one item per cycle while the output is not stalled; the
// register file is updated in the single cycle that moves an item from the
// input register to the result register.
// Reset (rst, synchronous): all state and reload controls go to zero,
// both stages empty.
// Stall: while m_tready is low the result holds; one more item waits in
// the input register, then s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pcm_dac_sample_engine_unit_defines.svh"

module pcm_dac_sample_engine_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // reg_sel[2:0], write_data[10:3], dma_word[26:11], count_gate[27], zero pad
  input  wire logic [pdse_pkg::S_TDATA_W-1:0] s_tdata,
  // func[1:0]
  input  wire logic [1:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // read_data[7:0], left_sample[23:8], right_sample[39:24],
  // irq_pending[40], count_expired[41], zero pad
  output logic [pdse_pkg::M_TDATA_W-1:0]      m_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_index,
  input  wire logic [15:0]                    cfg_data
);

  logic               s1_valid;
  pdse_pkg::item_t    s1_item;
  pdse_pkg::result_t  core_res;
  pdse_pkg::result_t  res;
  logic               advance;
  logic               s_fire;

  assign advance   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready  = !s1_valid || advance;
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      s1_item.func       <= s_tuser;
      s1_item.reg_sel    <= s_tdata[2:0];
      s1_item.write_data <= s_tdata[10:3];
      s1_item.dma_word   <= s_tdata[26:11];
      s1_item.count_gate <= s_tdata[27];
    end
  end

  pdse_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (advance),
    .item      (s1_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= core_res;
    end
  end

  assign m_tdata = {6'b000000, res.count_expired, res.irq_pending,
                    res.right_sample, res.left_sample, res.read_data};

  `PDSE_ASSERT_IMPL(a_full_stall_blocks, clk, rst,
    s1_valid && m_tvalid && !m_tready, !s_tready)
  `PDSE_ASSERT_IMPL(a_expire_only_tick, clk, rst,
    advance && core_res.count_expired, s1_item.func == pdse_pkg::FUNC_TICK)
  `PDSE_ASSERT_IMPL(a_read_data_idle, clk, rst,
    advance && (s1_item.func != pdse_pkg::FUNC_READ), core_res.read_data == pdse_pkg::RD_NONE)
  `PDSE_ASSERT(a_result_from_stage, clk, rst,
    $rose(m_tvalid) |-> $past(s1_valid))

endmodule

`default_nettype wire

// ===== dv/pcm_dac_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM DAC sample engine - stream monitor
// Watches the item, result and reload-control channels, keeps its own copy
// of the register file and counter, predicts the result of every accepted
// item and compares each returned result field by field, in order.
// ----------------------------------------------------------------------------
module pcm_dac_monitor
  import pdse_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   mismatches,
  output int                   outstanding
);

  logic [4:0]  st_bits;
  logic [4:0]  en_bits;
  logic [7:0]  filt_reg;
  logic [7:0]  pcm_reg;
  logic [7:0]  fmt_reg;
  logic [15:0] left_q;
  logic [15:0] right_q;
  logic        right_next;
  logic [15:0] samples_left;
  logic        halted;
  logic        reload_on;
  logic [15:0] reload_val;

  result_t dac_outputs_due[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic result_t dac_step(item_t it);
    result_t     r;
    logic        wide;
    logic        expired;
    logic [15:0] smp;
    r.read_data = RD_NONE;
    expired     = 1'b0;
    wide        = fmt_reg[FMT_16_BIT];
    case (it.func)
      FUNC_TICK: begin
        st_bits = st_bits | ST_SAMP;
        if (it.count_gate && !halted) begin
          if (pcm_reg[PC_ENA_BIT] || pcm_reg[PC_DMA_BIT]) begin
            smp = wide ? it.dma_word : {it.dma_word[7:0] ^ MSB_FLIP8, 8'h00};
            if (fmt_reg[FMT_INV_BIT])
              smp = smp ^ MSB_FLIP16;
            if (pcm_reg[PC_MONO_BIT]) begin
              left_q  = smp;
              right_q = smp;
            end else begin
              if (right_next)
                right_q = smp;
              else
                left_q = smp;
              right_next = ~right_next;
            end
          end
          samples_left = samples_left - (wide ? 16'd2 : 16'd1);
          if (samples_left == 16'd0) begin
            if (reload_on)
              samples_left = wide ? (reload_val & EVEN_MASK) : reload_val;
            else
              halted = 1'b1;
            st_bits = st_bits | ST_PCM;
            expired = 1'b1;
          end
        end
      end
      FUNC_WRITE: begin
        case (it.reg_sel)
          REG_STATUS: st_bits = st_bits & ~it.write_data[4:0];
          REG_MASK: en_bits = it.write_data[4:0];
          REG_FILTER: filt_reg = it.write_data;
          REG_PCM: begin
            if (it.write_data[PC_ENA_BIT] && !pcm_reg[PC_ENA_BIT])
              right_next = 1'b0;
            pcm_reg = it.write_data;
          end
          REG_FORMAT: fmt_reg = it.write_data;
          REG_COUNT_LO: begin
            samples_left[7:0] = it.write_data;
            halted = 1'b0;
          end
          REG_COUNT_HI: begin
            samples_left[15:8] = it.write_data;
            halted = 1'b0;
          end
          default: ;
        endcase
      end
      FUNC_READ: begin
        case (it.reg_sel)
          REG_STATUS: r.read_data = {3'b000, st_bits};
          REG_MASK: r.read_data = {3'b000, en_bits} | MASK_RD_SET;
          REG_FILTER: r.read_data = filt_reg;
          REG_PCM: r.read_data = pcm_reg;
          REG_FORMAT: r.read_data = fmt_reg;
          REG_COUNT_LO: r.read_data = samples_left[7:0];
          REG_COUNT_HI: r.read_data = samples_left[15:8];
          default: r.read_data = RD_NONE;
        endcase
      end
      default: ;
    endcase
    r.left_sample   = filt_reg[FILT_ON_BIT] ? left_q : 16'd0;
    r.right_sample  = filt_reg[FILT_ON_BIT] ? right_q : 16'd0;
    r.irq_pending   = |(st_bits & en_bits);
    r.count_expired = expired;
    return r;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    item_t   it;
    result_t got;
    result_t want;
    if (rst) begin
      st_bits      = '0;
      en_bits      = '0;
      filt_reg     = '0;
      pcm_reg      = '0;
      fmt_reg      = '0;
      left_q       = '0;
      right_q      = '0;
      right_next   = 1'b0;
      samples_left = '0;
      halted       = 1'b0;
      reload_on    = 1'b0;
      reload_val   = '0;
      dac_outputs_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_AUTO_RELOAD)
          reload_on = cfg_data[0];
        else
          reload_val = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        got.read_data     = m_tdata[7:0];
        got.left_sample   = m_tdata[23:8];
        got.right_sample  = m_tdata[39:24];
        got.irq_pending   = m_tdata[40];
        got.count_expired = m_tdata[41];
        if (dac_outputs_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
        end else begin
          want = dac_outputs_due.pop_front();
          compare_field("read_data", {8'h00, want.read_data}, {8'h00, got.read_data});
          compare_field("left_sample", want.left_sample, got.left_sample);
          compare_field("right_sample", want.right_sample, got.right_sample);
          compare_field("irq_pending", {15'd0, want.irq_pending}, {15'd0, got.irq_pending});
          compare_field("count_expired", {15'd0, want.count_expired},
                        {15'd0, got.count_expired});
        end
      end
      if (s_tvalid && s_tready) begin
        it.func       = s_tuser;
        it.reg_sel    = s_tdata[2:0];
        it.write_data = s_tdata[10:3];
        it.dma_word   = s_tdata[26:11];
        it.count_gate = s_tdata[27];
        dac_outputs_due.push_back(dac_step(it));
      end
    end
    outstanding = dac_outputs_due.size();
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PCM DAC sample engine - testbench top
// Drives register accesses and sample ticks into the engine: a directed
// pass over every register, both sample formats, mono and stereo, counter
// expiry, stop and reload, then random traffic under four reload settings
// with random idling on both sides, a long output stall and a full drain.
// ----------------------------------------------------------------------------
module testbench;
  import pdse_pkg::*;

  localparam logic [1:0] FUNC_UNUSED  = 2'd3;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int         CYCLE_LIMIT  = 500000;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [1:0]           s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic                 cfg_index;
  logic [15:0]          cfg_data;
  int                   mismatches;
  int                   outstanding;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;

  pcm_dac_sample_engine_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pcm_dac_monitor monitor (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles--;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic item_t make_item(logic [1:0] f, logic [2:0] sel, logic [7:0] wd,
                                      logic [15:0] dma, logic gate);
    item_t it;
    it.func       = f;
    it.reg_sel    = sel;
    it.write_data = wd;
    it.dma_word   = dma;
    it.count_gate = gate;
    return it;
  endfunction

  // keep counts short so expiry, stop and reload come around often
  function automatic item_t random_access();
    item_t       it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50)
      it.func = FUNC_TICK;
    else if (pick < 78)
      it.func = FUNC_WRITE;
    else if (pick < 96)
      it.func = FUNC_READ;
    else
      it.func = FUNC_UNUSED;
    it.reg_sel    = 3'($urandom_range(7));
    it.write_data = 8'($urandom_range(255));
    it.dma_word   = 16'($urandom_range(16'hffff));
    it.count_gate = ($urandom_range(99) < 80);
    if (it.func == FUNC_WRITE && it.reg_sel == REG_COUNT_HI && $urandom_range(99) < 85)
      it.write_data = 8'h00;
    if (it.func == FUNC_WRITE && it.reg_sel == REG_COUNT_LO && $urandom_range(99) < 80)
      it.write_data = 8'($urandom_range(12));
    return it;
  endfunction

  task automatic offer(item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {4'b0000, it.count_gate, it.dma_word, it.write_data, it.reg_sel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int send_pct, int recv_pct, logic reload_en,
                           logic [15:0] reload, int n);
    drain();
    write_cfg(CFG_AUTO_RELOAD, {15'd0, reload_en});
    write_cfg(CFG_COUNT_RELOAD, reload);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n; i++) begin
      // long output stall while items keep coming, later a full drain
      if (i == n / 3)
        hold_cycles = 250;
      if (i == 2 * n / 3)
        drain();
      offer(random_access());
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    m_tready      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = 1'b0;
    cfg_data      = '0;
    send_idle_pct = 10;
    recv_idle_pct = 85;
    hold_cycles   = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_cfg(CFG_AUTO_RELOAD, 16'd0);
    write_cfg(CFG_COUNT_RELOAD, 16'd0);
    offer(make_item(FUNC_TICK, REG_STATUS, 8'h00, 16'h0000, 1'b1));
    for (int r = 0; r < 8; r++)
      offer(make_item(FUNC_READ, 3'(r), 8'h00, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_MASK, 8'h1f, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_FILTER, 8'hff, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_PCM, 8'h40, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_FORMAT, 8'h10, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_COUNT_LO, 8'h02, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_COUNT_HI, 8'h00, 16'h0000, 1'b0));
    offer(make_item(FUNC_TICK, REG_STATUS, 8'h00, 16'h0000, 1'b1));
    offer(make_item(FUNC_TICK, REG_STATUS, 8'h00, 16'hffff, 1'b1));
    offer(make_item(FUNC_TICK, REG_STATUS, 8'h00, 16'h1234, 1'b1));
    offer(make_item(FUNC_TICK, REG_STATUS, 8'h00, 16'h5678, 1'b0));
    offer(make_item(FUNC_WRITE, REG_STATUS, 8'hff, 16'h0000, 1'b0));
    offer(make_item(FUNC_UNUSED, REG_FILTER, 8'h00, 16'hffff, 1'b1));
    offer(make_item(FUNC_WRITE, REG_UNMAPPED, 8'hff, 16'h0000, 1'b0));
    offer(make_item(FUNC_READ, REG_UNMAPPED, 8'h00, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_PCM, 8'ha0, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_FORMAT, 8'h04, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_COUNT_LO, 8'h03, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_COUNT_HI, 8'h80, 16'h0000, 1'b0));
    offer(make_item(FUNC_TICK, REG_STATUS, 8'h00, 16'h8001, 1'b1));

    drain();
    write_cfg(CFG_AUTO_RELOAD, 16'd1);
    write_cfg(CFG_COUNT_RELOAD, 16'hffff);
    offer(make_item(FUNC_WRITE, REG_COUNT_LO, 8'h02, 16'h0000, 1'b0));
    offer(make_item(FUNC_WRITE, REG_COUNT_HI, 8'h00, 16'h0000, 1'b0));
    offer(make_item(FUNC_TICK, REG_STATUS, 8'h00, 16'h7fff, 1'b1));
    offer(make_item(FUNC_READ, REG_COUNT_LO, 8'h00, 16'h0000, 1'b0));
    offer(make_item(FUNC_READ, REG_COUNT_HI, 8'h00, 16'h0000, 1'b0));

    run_phase(10, 85, 1'b1, 16'hffff, 630);
    run_phase(85, 10, 1'b0, 16'd5, 630);
    run_phase(0, 0, 1'b1, 16'd1, 315);
    run_phase(0, 0, 1'b1, 16'd0, 315);

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== pcm_dac_sample_engine_unit.f =====
+incdir+sv
sv/pdse_pkg.sv
sv/pdse_core.sv
sv/pcm_dac_sample_engine_unit.sv
dv/pcm_dac_monitor.sv
dv/testbench.sv
